### sv/assert_macros.svh
// Assertion macros shared by the instruction core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define C8_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every edge, reset included.
`define C8_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/c8ic_pkg.sv
// Shared constants, types and command structs of the instruction core.
`default_nettype none
package c8ic_pkg;
   localparam int STACK_DEPTH   = 16;
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int MEM_BYTES     = 4096;
   localparam int MEM_AW        = $clog2(MEM_BYTES);
   localparam int ROW_AW        = $clog2(SCREEN_HEIGHT);
   localparam int COL_AW        = $clog2(SCREEN_WIDTH);
   localparam int SP_W          = $clog2(STACK_DEPTH + 1);
   localparam int SLOT_W        = $clog2(STACK_DEPTH);

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 56;

   localparam logic [12:0] PC_RESET    = 13'h200;
   localparam logic [12:0] PC_LIMIT    = 13'(MEM_BYTES);
   localparam logic [15:0] INST_CLS    = 16'h00E0;
   localparam logic [15:0] INST_RET    = 16'h00EE;
   localparam logic [7:0]  KEY_HELD    = 8'h9E;
   localparam logic [7:0]  KEY_UP      = 8'hA1;
   localparam logic [7:0]  F_GET_DELAY = 8'h07;
   localparam logic [7:0]  F_WAIT_KEY  = 8'h0A;
   localparam logic [7:0]  F_SET_DELAY = 8'h15;
   localparam logic [7:0]  F_SET_SOUND = 8'h18;
   localparam logic [7:0]  F_ADD_INDEX = 8'h1E;
   localparam logic [4:0]  KEY_NONE    = 5'd16;

   localparam logic [0:0] CSR_SHIFT_USES_VY     = 1'd0;
   localparam logic [0:0] CSR_JUMP_OFFSET_USES_VX = 1'd1;

   typedef logic [SCREEN_WIDTH-1:0] row_type;
   typedef logic [ROW_AW-1:0]       row_addr_type;
   typedef logic [COL_AW-1:0]       col_addr_type;
   typedef logic [MEM_AW-1:0]       mem_addr_type;
   typedef logic [SP_W-1:0]         sp_type;
   typedef logic [SLOT_W-1:0]       slot_type;

   typedef enum logic [2:0] {
      OPC_MEM_WRITE, OPC_MEM_READ, OPC_EXECUTE, OPC_TICK, OPC_PIXEL_READ, OPC_REG_READ
   } opc_type;

   typedef enum logic [3:0] {
      GRP_SYS, GRP_JUMP, GRP_CALL, GRP_SKIP_EQ_NN, GRP_SKIP_NE_NN, GRP_SKIP_EQ_REG,
      GRP_LOAD_NN, GRP_ADD_NN, GRP_ALU, GRP_SKIP_NE_REG, GRP_LOAD_INDEX,
      GRP_JUMP_OFFSET, GRP_RANDOM, GRP_DRAW, GRP_KEY, GRP_MISC
   } grp_type;

   typedef enum logic [3:0] {
      ALU_MOV  = 4'h0, ALU_OR  = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3,
      ALU_ADD  = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7,
      ALU_SHL  = 4'hE
   } alu_type;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_DISPATCH, ST_MEM_WAIT, ST_PIX_WAIT, ST_FETCH_LO,
      ST_DECODE, ST_READ_Y, ST_EXEC, ST_DRAW_RD, ST_DRAW_WR, ST_DRAW_END, ST_RESP
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NONE, DP_INIT_STEP, DP_MEM_WRITE, DP_MEM_READ, DP_CAP_MEM, DP_TICK,
      DP_PIX_READ, DP_CAP_PIX, DP_REG_READ, DP_FETCH_HI, DP_FETCH_LO, DP_DECODE,
      DP_READ_Y, DP_EXEC, DP_DRAW_RD, DP_DRAW_WR
   } dp_op_type;

   typedef struct packed {
      logic      capture;
      dp_op_type op;
      logic      draw_end;
      logic      rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic       init_last;
      logic [2:0] opcode;
      logic       is_draw;
      logic       draw_more;
   } dp_status_type;
endpackage
`default_nettype wire

### sv/c8ic_ctrl.sv
// Sequencer for the instruction core: steps each item through the datapath.
`default_nettype none
`include "assert_macros.svh"
module c8ic_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire c8ic_pkg::dp_status_type  status,
   output c8ic_pkg::dp_cmd_type          cmd
);
   c8ic_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff;

   assign req_tready = (state_ff == c8ic_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         c8ic_pkg::ST_INIT:     if (status.init_last) state_in = c8ic_pkg::ST_IDLE;
         c8ic_pkg::ST_IDLE:     if (req_tvalid) state_in = c8ic_pkg::ST_DISPATCH;
         c8ic_pkg::ST_DISPATCH: begin
            case (status.opcode)
               c8ic_pkg::OPC_MEM_READ:   state_in = c8ic_pkg::ST_MEM_WAIT;
               c8ic_pkg::OPC_EXECUTE:    state_in = c8ic_pkg::ST_FETCH_LO;
               c8ic_pkg::OPC_PIXEL_READ: state_in = c8ic_pkg::ST_PIX_WAIT;
               default:                  state_in = c8ic_pkg::ST_RESP;
            endcase
         end
         c8ic_pkg::ST_MEM_WAIT: state_in = c8ic_pkg::ST_RESP;
         c8ic_pkg::ST_PIX_WAIT: state_in = c8ic_pkg::ST_RESP;
         c8ic_pkg::ST_FETCH_LO: state_in = c8ic_pkg::ST_DECODE;
         c8ic_pkg::ST_DECODE:   state_in = c8ic_pkg::ST_READ_Y;
         c8ic_pkg::ST_READ_Y:   state_in = c8ic_pkg::ST_EXEC;
         c8ic_pkg::ST_EXEC: begin
            state_in = status.is_draw ? c8ic_pkg::ST_DRAW_RD : c8ic_pkg::ST_RESP;
         end
         c8ic_pkg::ST_DRAW_RD: begin
            state_in = status.draw_more ? c8ic_pkg::ST_DRAW_WR : c8ic_pkg::ST_DRAW_END;
         end
         c8ic_pkg::ST_DRAW_WR:  state_in = c8ic_pkg::ST_DRAW_RD;
         c8ic_pkg::ST_DRAW_END: state_in = c8ic_pkg::ST_RESP;
         c8ic_pkg::ST_RESP:     if (!rsp_valid_ff || rsp_tready) state_in = c8ic_pkg::ST_IDLE;
         default:               state_in = c8ic_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{capture: 1'b0, op: c8ic_pkg::DP_NONE, draw_end: 1'b0, rsp_load: 1'b0};
      case (state_ff)
         c8ic_pkg::ST_INIT:     cmd.op = c8ic_pkg::DP_INIT_STEP;
         c8ic_pkg::ST_IDLE:     cmd.capture = req_tvalid;
         c8ic_pkg::ST_DISPATCH: begin
            case (status.opcode)
               c8ic_pkg::OPC_MEM_WRITE:  cmd.op = c8ic_pkg::DP_MEM_WRITE;
               c8ic_pkg::OPC_MEM_READ:   cmd.op = c8ic_pkg::DP_MEM_READ;
               c8ic_pkg::OPC_EXECUTE:    cmd.op = c8ic_pkg::DP_FETCH_HI;
               c8ic_pkg::OPC_TICK:       cmd.op = c8ic_pkg::DP_TICK;
               c8ic_pkg::OPC_PIXEL_READ: cmd.op = c8ic_pkg::DP_PIX_READ;
               c8ic_pkg::OPC_REG_READ:   cmd.op = c8ic_pkg::DP_REG_READ;
               default:                  cmd.op = c8ic_pkg::DP_NONE;
            endcase
         end
         c8ic_pkg::ST_MEM_WAIT: cmd.op = c8ic_pkg::DP_CAP_MEM;
         c8ic_pkg::ST_PIX_WAIT: cmd.op = c8ic_pkg::DP_CAP_PIX;
         c8ic_pkg::ST_FETCH_LO: cmd.op = c8ic_pkg::DP_FETCH_LO;
         c8ic_pkg::ST_DECODE:   cmd.op = c8ic_pkg::DP_DECODE;
         c8ic_pkg::ST_READ_Y:   cmd.op = c8ic_pkg::DP_READ_Y;
         c8ic_pkg::ST_EXEC:     cmd.op = c8ic_pkg::DP_EXEC;
         c8ic_pkg::ST_DRAW_RD:  if (status.draw_more) cmd.op = c8ic_pkg::DP_DRAW_RD;
         c8ic_pkg::ST_DRAW_WR:  cmd.op = c8ic_pkg::DP_DRAW_WR;
         c8ic_pkg::ST_DRAW_END: cmd.draw_end = 1'b1;
         c8ic_pkg::ST_RESP:     cmd.rsp_load = !rsp_valid_ff || rsp_tready;
         default:               cmd.op = c8ic_pkg::DP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= c8ic_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `C8_ASSERT(a_rsp_no_overwrite, cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready), "result overwritten")
   `C8_ASSERT(a_accept_dispatch, (req_tvalid && req_tready) |=> (state_ff == c8ic_pkg::ST_DISPATCH), "accept not dispatched")
   `C8_ASSERT(a_load_shows, cmd.rsp_load |=> rsp_tvalid, "loaded result not presented")
endmodule
`default_nettype wire

### sv/c8ic_datapath.sv
// Datapath: memory, screen rows, registers, stack, ALU and result register.
`default_nettype none
`include "assert_macros.svh"
module c8ic_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [c8ic_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic [c8ic_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic [c8ic_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [0:0]                          csr_index,
   input  wire logic [0:0]                          csr_wdata,
   input  wire c8ic_pkg::dp_cmd_type                cmd,
   output c8ic_pkg::dp_status_type                  status
);
   logic shift_vy_ff, jump_vx_ff;

   logic [2:0]  opc_ff;
   logic [11:0] addr_ff;
   logic [7:0]  wdata_ff;
   logic [15:0] keys_ff;
   logic [4:0]  pkey_ff;
   logic [7:0]  rnd_ff;
   logic [5:0]  px_ff;
   logic [4:0]  py_ff;
   logic [3:0]  ridx_ff;

   logic [12:0] pc_ff, pc_in;
   logic [15:0] index_ff, index_in;
   logic [7:0]  delay_ff, delay_in, sound_ff, sound_in;
   logic [7:0]  gp_ff [16];
   logic [7:0]  gp_in [16];
   logic [12:0] stack_ff [c8ic_pkg::STACK_DEPTH];
   c8ic_pkg::sp_type sp_ff, sp_in;
   logic push_en;

   logic [7:0] mem [c8ic_pkg::MEM_BYTES];
   logic [7:0] mem_q_ff;
   logic mem_we;
   c8ic_pkg::mem_addr_type mem_wa, mem_ra;
   logic [7:0] mem_wd;
   c8ic_pkg::mem_addr_type init_cnt_ff;

   c8ic_pkg::row_type screen [c8ic_pkg::SCREEN_HEIGHT];
   c8ic_pkg::row_type row_q_ff;
   logic [c8ic_pkg::SCREEN_HEIGHT-1:0] live_ff, live_in;
   c8ic_pkg::row_addr_type scr_ra, draw_row;

   logic [15:0] inst_ff;
   logic [7:0]  vx_ff, vy_ff;
   logic [3:0]  gp_ra;
   logic [7:0]  gp_rd;
   c8ic_pkg::col_addr_type ox_ff;
   c8ic_pkg::row_addr_type oy_ff;
   logic [4:0] row_ff;
   logic hit_ff, chg_ff;

   logic [7:0] rdata_ff, rdata_in;
   logic serr_ff, serr_in, wait_ff, wait_in, dchg_ff, dchg_in;
   logic [c8ic_pkg::RSP_DATA_W-1:0] rsp_ff;

   logic [12:0] pc_wrap, stack_top;
   logic [7:0]  sprite_rev, shift_src;
   logic [8:0]  sum9;
   c8ic_pkg::row_type mask, old_row, new_row;
   logic [3:0] x, n;
   logic [7:0] nn;
   logic held;

   assign x  = inst_ff[11:8];
   assign n  = inst_ff[3:0];
   assign nn = inst_ff[7:0];
   assign pc_wrap   = (pc_ff >= c8ic_pkg::PC_LIMIT) ? c8ic_pkg::PC_RESET : pc_ff;
   assign stack_top = stack_ff[c8ic_pkg::slot_type'(sp_ff - 1'b1)];
   assign draw_row  = oy_ff + c8ic_pkg::row_addr_type'(row_ff);
   assign shift_src = shift_vy_ff ? vy_ff : vx_ff;
   assign sum9      = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign held      = keys_ff[x];
   assign rsp_tdata = rsp_ff;

   always_comb begin
      for (int b = 0; b < 8; b++) sprite_rev[b] = mem_q_ff[7-b];
   end
   assign mask    = c8ic_pkg::row_type'(sprite_rev) << ox_ff;
   assign old_row = live_ff[draw_row] ? row_q_ff : '0;
   assign new_row = old_row ^ mask;

   always_comb begin
      case (cmd.op)
         c8ic_pkg::DP_DECODE: begin
            gp_ra = (inst_ff[15:12] == c8ic_pkg::GRP_JUMP_OFFSET && !jump_vx_ff) ? 4'd0 : x;
         end
         c8ic_pkg::DP_READ_Y: gp_ra = inst_ff[7:4];
         default:             gp_ra = ridx_ff;
      endcase
   end
   assign gp_rd = gp_ff[gp_ra];

   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = wdata_ff;
      mem_ra = addr_ff;
      case (cmd.op)
         c8ic_pkg::DP_INIT_STEP: begin
            mem_we = 1'b1;
            mem_wa = init_cnt_ff;
            mem_wd = 8'd0;
         end
         c8ic_pkg::DP_MEM_WRITE: mem_we = 1'b1;
         c8ic_pkg::DP_FETCH_HI:  mem_ra = pc_wrap[11:0];
         c8ic_pkg::DP_FETCH_LO:  mem_ra = pc_ff[11:0] + 12'd1;
         c8ic_pkg::DP_DRAW_RD:   mem_ra = index_ff[11:0] + {7'd0, row_ff};
         default:                mem_ra = addr_ff;
      endcase
      scr_ra = (cmd.op == c8ic_pkg::DP_PIX_READ) ? c8ic_pkg::row_addr_type'(py_ff) : draw_row;
   end

   always_comb begin
      pc_in    = pc_ff;
      index_in = index_ff;
      delay_in = delay_ff;
      sound_in = sound_ff;
      gp_in    = gp_ff;
      sp_in    = sp_ff;
      push_en  = 1'b0;
      live_in  = live_ff;
      rdata_in = rdata_ff;
      serr_in  = serr_ff;
      wait_in  = wait_ff;
      dchg_in  = dchg_ff;
      case (cmd.op)
         c8ic_pkg::DP_TICK: begin
            if (delay_ff != 8'd0) delay_in = delay_ff - 8'd1;
            if (sound_ff != 8'd0) sound_in = sound_ff - 8'd1;
         end
         c8ic_pkg::DP_CAP_MEM:  rdata_in = mem_q_ff;
         c8ic_pkg::DP_CAP_PIX: begin
            if (int'(px_ff) < c8ic_pkg::SCREEN_WIDTH && int'(py_ff) < c8ic_pkg::SCREEN_HEIGHT
                && live_ff[c8ic_pkg::row_addr_type'(py_ff)]) begin
               rdata_in = {7'd0, row_q_ff[c8ic_pkg::col_addr_type'(px_ff)]};
            end else begin
               rdata_in = 8'd0;
            end
         end
         c8ic_pkg::DP_REG_READ: rdata_in = gp_rd;
         c8ic_pkg::DP_FETCH_HI: pc_in = pc_wrap;
         c8ic_pkg::DP_EXEC: begin
            pc_in = pc_ff + 13'd2;
            case (c8ic_pkg::grp_type'(inst_ff[15:12]))
               c8ic_pkg::GRP_SYS: begin
                  if (inst_ff == c8ic_pkg::INST_CLS) begin
                     dchg_in = |live_ff;
                     live_in = '0;
                  end else if (inst_ff == c8ic_pkg::INST_RET) begin
                     if (sp_ff == '0) begin
                        serr_in = 1'b1;
                     end else begin
                        sp_in = sp_ff - 1'b1;
                        pc_in = stack_top + 13'd2;
                     end
                  end
               end
               c8ic_pkg::GRP_JUMP: pc_in = {1'b0, inst_ff[11:0]};
               c8ic_pkg::GRP_CALL: begin
                  if (sp_ff >= c8ic_pkg::sp_type'(c8ic_pkg::STACK_DEPTH)) begin
                     serr_in = 1'b1;
                  end else begin
                     push_en = 1'b1;
                     sp_in   = sp_ff + 1'b1;
                     pc_in   = {1'b0, inst_ff[11:0]};
                  end
               end
               c8ic_pkg::GRP_SKIP_EQ_NN:  if (vx_ff == nn) pc_in = pc_ff + 13'd4;
               c8ic_pkg::GRP_SKIP_NE_NN:  if (vx_ff != nn) pc_in = pc_ff + 13'd4;
               c8ic_pkg::GRP_SKIP_EQ_REG: if (vx_ff == vy_ff) pc_in = pc_ff + 13'd4;
               c8ic_pkg::GRP_SKIP_NE_REG: if (vx_ff != vy_ff) pc_in = pc_ff + 13'd4;
               c8ic_pkg::GRP_LOAD_NN:     gp_in[x] = nn;
               c8ic_pkg::GRP_ADD_NN:      gp_in[x] = vx_ff + nn;
               c8ic_pkg::GRP_ALU: begin
                  case (n)
                     c8ic_pkg::ALU_MOV: gp_in[x] = vy_ff;
                     c8ic_pkg::ALU_OR:  gp_in[x] = vx_ff | vy_ff;
                     c8ic_pkg::ALU_AND: gp_in[x] = vx_ff & vy_ff;
                     c8ic_pkg::ALU_XOR: gp_in[x] = vx_ff ^ vy_ff;
                     c8ic_pkg::ALU_ADD: begin
                        gp_in[15] = {7'd0, sum9[8]};
                        gp_in[x]  = sum9[7:0];
                     end
                     c8ic_pkg::ALU_SUB: begin
                        gp_in[15] = {7'd0, vx_ff >= vy_ff};
                        gp_in[x]  = vx_ff - vy_ff;
                     end
                     c8ic_pkg::ALU_SHR: begin
                        gp_in[15] = {7'd0, shift_src[0]};
                        gp_in[x]  = shift_src >> 1;
                     end
                     c8ic_pkg::ALU_SUBN: begin
                        gp_in[15] = {7'd0, vy_ff >= vx_ff};
                        gp_in[x]  = vy_ff - vx_ff;
                     end
                     c8ic_pkg::ALU_SHL: begin
                        gp_in[15] = {7'd0, shift_src[7]};
                        gp_in[x]  = shift_src << 1;
                     end
                     default: ;
                  endcase
               end
               c8ic_pkg::GRP_LOAD_INDEX:  index_in = {4'd0, inst_ff[11:0]};
               c8ic_pkg::GRP_JUMP_OFFSET: pc_in = {1'b0, inst_ff[11:0]} + {5'd0, vx_ff};
               c8ic_pkg::GRP_RANDOM:      gp_in[x] = rnd_ff & nn;
               c8ic_pkg::GRP_KEY: begin
                  if ((nn == c8ic_pkg::KEY_HELD && held) || (nn == c8ic_pkg::KEY_UP && !held)) begin
                     pc_in = pc_ff + 13'd4;
                  end
               end
               c8ic_pkg::GRP_MISC: begin
                  case (nn)
                     c8ic_pkg::F_GET_DELAY: gp_in[x] = delay_ff;
                     c8ic_pkg::F_SET_DELAY: delay_in = vx_ff;
                     c8ic_pkg::F_SET_SOUND: sound_in = vx_ff;
                     c8ic_pkg::F_ADD_INDEX: index_in = index_ff + {8'd0, vx_ff};
                     c8ic_pkg::F_WAIT_KEY: begin
                        if (pkey_ff < c8ic_pkg::KEY_NONE) begin
                           gp_in[x] = {4'd0, pkey_ff[3:0]};
                        end else begin
                           pc_in   = pc_ff;
                           wait_in = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
         c8ic_pkg::DP_DRAW_WR: live_in[draw_row] = |new_row;
         default: ;
      endcase
      if (cmd.draw_end) begin
         gp_in[15] = {7'd0, hit_ff};
         dchg_in   = chg_ff;
      end
      if (cmd.capture) begin
         rdata_in = 8'd0;
         serr_in  = 1'b0;
         wait_in  = 1'b0;
         dchg_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == c8ic_pkg::DP_DRAW_WR) screen[draw_row] <= new_row;
      row_q_ff <= screen[scr_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_vy_ff <= 1'b0;
         jump_vx_ff  <= 1'b0;
         pc_ff       <= c8ic_pkg::PC_RESET;
         index_ff    <= 16'd0;
         delay_ff    <= 8'd0;
         sound_ff    <= 8'd0;
         sp_ff       <= '0;
         live_ff     <= '0;
         init_cnt_ff <= '0;
         for (int i = 0; i < 16; i++) gp_ff[i] <= 8'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               c8ic_pkg::CSR_SHIFT_USES_VY:       shift_vy_ff <= csr_wdata[0];
               c8ic_pkg::CSR_JUMP_OFFSET_USES_VX: jump_vx_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         pc_ff    <= pc_in;
         index_ff <= index_in;
         delay_ff <= delay_in;
         sound_ff <= sound_in;
         sp_ff    <= sp_in;
         live_ff  <= live_in;
         gp_ff    <= gp_in;
         if (cmd.op == c8ic_pkg::DP_INIT_STEP) init_cnt_ff <= init_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) stack_ff[c8ic_pkg::slot_type'(sp_ff)] <= pc_ff;
      if (cmd.capture) begin
         opc_ff   <= req_tuser;
         addr_ff  <= req_tdata[11:0];
         wdata_ff <= req_tdata[19:12];
         keys_ff  <= req_tdata[35:20];
         pkey_ff  <= req_tdata[40:36];
         rnd_ff   <= req_tdata[48:41];
         px_ff    <= req_tdata[54:49];
         py_ff    <= req_tdata[59:55];
         ridx_ff  <= req_tdata[63:60];
      end
      if (cmd.op == c8ic_pkg::DP_FETCH_LO) inst_ff[15:8] <= mem_q_ff;
      if (cmd.op == c8ic_pkg::DP_DECODE) begin
         inst_ff[7:0] <= mem_q_ff;
         vx_ff        <= gp_rd;
      end
      if (cmd.op == c8ic_pkg::DP_READ_Y) vy_ff <= gp_rd;
      if (cmd.op == c8ic_pkg::DP_EXEC) begin
         // screen sizes are powers of two: the origin wraps by dropping high bits
         ox_ff  <= vx_ff[c8ic_pkg::COL_AW-1:0];
         oy_ff  <= vy_ff[c8ic_pkg::ROW_AW-1:0];
         row_ff <= 5'd0;
         hit_ff <= 1'b0;
         chg_ff <= 1'b0;
      end
      if (cmd.op == c8ic_pkg::DP_DRAW_WR) begin
         row_ff <= row_ff + 5'd1;
         hit_ff <= hit_ff | (|(old_row & mask));
         chg_ff <= chg_ff | (|mask);
      end
      rdata_ff <= rdata_in;
      serr_ff  <= serr_in;
      wait_ff  <= wait_in;
      dchg_ff  <= dchg_in;
      if (cmd.rsp_load) begin
         rsp_ff <= {dchg_ff, wait_ff, serr_ff, rdata_ff, sound_ff, delay_ff, index_ff, pc_ff};
      end
   end

   assign status.init_last = (init_cnt_ff == c8ic_pkg::mem_addr_type'(c8ic_pkg::MEM_BYTES - 1));
   assign status.opcode    = opc_ff;
   assign status.is_draw   = (inst_ff[15:12] == c8ic_pkg::GRP_DRAW);
   assign status.draw_more = (row_ff < {1'b0, n})
      && (({1'b0, oy_ff} + (c8ic_pkg::ROW_AW + 1)'(row_ff))
          < (c8ic_pkg::ROW_AW + 1)'(c8ic_pkg::SCREEN_HEIGHT));

   `C8_ASSERT(a_sp_bound, sp_ff <= c8ic_pkg::sp_type'(c8ic_pkg::STACK_DEPTH), "stack depth out of range")
endmodule
`default_nettype wire

### sv/chip8_instruction_core_top.sv
// Top level of the CHIP-8 style instruction core.
// One item in, one result out. Memory write, tick, register read and undefined
// opcodes go straight to the result, memory and pixel reads add a wait state, execute
// adds fetch, decode, Vy read and execute states, and a sprite draw adds a read and a
// write per drawn row (one memory and one screen-row access each) plus an end state.
// After reset the block zeroes the 4 KiB memory, one byte per cycle, before it accepts
// an item. The next item is taken while a finished result still waits on rsp.
`default_nettype none
module chip8_instruction_core_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // address, data_byte, key_mask, pressed_key, random_byte, pixel_x, pixel_y, reg_index
   input  wire logic [63:0] req_tdata,
   // opcode
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pc, index_value, delay_value, sound_value, read_data, stack_error,
   // waiting_key, display_changed
   output logic [55:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [0:0]  csr_wdata
);
   c8ic_pkg::dp_cmd_type    cmd;
   c8ic_pkg::dp_status_type status;

   c8ic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   c8ic_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );
endmodule
`default_nettype wire

### tb/tb_chip8_instruction_core_top.sv
// Self-checking testbench for the CHIP-8 instruction core: programs, timers, reads, draws.
`default_nettype none
module tb_chip8_instruction_core_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OPC_UNDEF_6 = 3'd6;
   localparam logic [2:0] OPC_UNDEF_7 = 3'd7;
   localparam int IDLE_WAIT  = 50;
   localparam int STALL_LIMIT = 12000;
   localparam int LONG_HOLD  = 400;

   typedef struct {
      logic [2:0]  op;
      logic [11:0] addr;
      logic [7:0]  data;
      logic [15:0] keys;
      logic [4:0]  pressed;
      logic [7:0]  rnd;
      logic [5:0]  px;
      logic [4:0]  py;
      logic [3:0]  ridx;
   } core_request;

   typedef struct {
      logic [12:0] pc;
      logic [15:0] index_value;
      logic [7:0]  delay_value;
      logic [7:0]  sound_value;
      logic [7:0]  read_data;
      logic        stack_error;
      logic        waiting_key;
      logic        display_changed;
   } core_result;

   class core_scoreboard;
      bit          shift_vy, jump_vx, failed;
      logic [7:0]  mem [c8ic_pkg::MEM_BYTES];
      bit          scr [c8ic_pkg::SCREEN_WIDTH*c8ic_pkg::SCREEN_HEIGHT];
      logic [7:0]  v [16];
      logic [12:0] pc;
      logic [15:0] idx;
      logic [7:0]  dt, st;
      logic [12:0] stk [c8ic_pkg::STACK_DEPTH];
      int          depth;
      core_result  expected_q [$];

      function new();
         foreach (mem[i]) mem[i] = 0;
         foreach (scr[i]) scr[i] = 0;
         foreach (v[i]) v[i] = 0;
         foreach (stk[i]) stk[i] = 0;
         pc = c8ic_pkg::PC_RESET; idx = 0; dt = 0; st = 0; depth = 0;
         shift_vy = 0; jump_vx = 0; failed = 0;
      endfunction

      function bit draw(logic [3:0] x, logic [3:0] y, logic [3:0] n);
         int ox, oy, rr, b;
         logic [11:0] ma;
         logic [7:0] bits;
         bit ch, fl;
         ox = v[x] % c8ic_pkg::SCREEN_WIDTH;
         oy = v[y] % c8ic_pkg::SCREEN_HEIGHT;
         ch = 0; fl = 0;
         for (rr = 0; rr < n && oy + rr < c8ic_pkg::SCREEN_HEIGHT; rr++) begin
            ma = idx[11:0] + 12'(rr);
            bits = mem[ma];
            for (b = 0; b < 8 && ox + b < c8ic_pkg::SCREEN_WIDTH; b++) begin
               if (bits[7-b]) begin
                  if (scr[(oy+rr)*c8ic_pkg::SCREEN_WIDTH + ox + b]) fl = 1;
                  scr[(oy+rr)*c8ic_pkg::SCREEN_WIDTH + ox + b] ^= 1'b1;
                  ch = 1;
               end
            end
         end
         v[15] = {7'd0, fl};
         return ch;
      endfunction

      function void execute(core_request r, inout core_result e);
         logic [12:0] p;
         logic [11:0] a1, nnn;
         logic [15:0] inst;
         logic [3:0]  x, y, n;
         logic [7:0]  nn, vx, vy, res, fl;
         bit          wr, ch;
         if (pc >= c8ic_pkg::PC_LIMIT) pc = c8ic_pkg::PC_RESET;
         p = pc;
         a1 = p[11:0] + 12'd1;
         inst = {mem[p[11:0]], mem[a1]};
         x = inst[11:8]; y = inst[7:4]; n = inst[3:0];
         nn = inst[7:0]; nnn = inst[11:0];
         case (c8ic_pkg::grp_type'(inst[15:12]))
            c8ic_pkg::GRP_SYS: begin
               if (inst == c8ic_pkg::INST_CLS) begin
                  ch = 0;
                  foreach (scr[i]) begin
                     if (scr[i]) ch = 1;
                     scr[i] = 0;
                  end
                  e.display_changed = ch;
               end else if (inst == c8ic_pkg::INST_RET) begin
                  if (depth == 0) e.stack_error = 1;
                  else begin
                     depth--;
                     p = stk[depth];
                  end
               end
            end
            c8ic_pkg::GRP_JUMP: p = {1'b0, nnn} - 13'd2;
            c8ic_pkg::GRP_CALL: begin
               if (depth >= c8ic_pkg::STACK_DEPTH) e.stack_error = 1;
               else begin
                  stk[depth] = p;
                  depth++;
                  p = {1'b0, nnn} - 13'd2;
               end
            end
            c8ic_pkg::GRP_SKIP_EQ_NN:  if (v[x] == nn) p += 13'd2;
            c8ic_pkg::GRP_SKIP_NE_NN:  if (v[x] != nn) p += 13'd2;
            c8ic_pkg::GRP_SKIP_EQ_REG: if (v[x] == v[y]) p += 13'd2;
            c8ic_pkg::GRP_LOAD_NN:     v[x] = nn;
            c8ic_pkg::GRP_ADD_NN:      v[x] = v[x] + nn;
            c8ic_pkg::GRP_ALU: begin
               vx = v[x]; vy = v[y]; wr = 1;
               case (c8ic_pkg::alu_type'(n))
                  c8ic_pkg::ALU_MOV: begin v[x] = vy; wr = 0; end
                  c8ic_pkg::ALU_OR:  begin v[x] = vx | vy; wr = 0; end
                  c8ic_pkg::ALU_AND: begin v[x] = vx & vy; wr = 0; end
                  c8ic_pkg::ALU_XOR: begin v[x] = vx ^ vy; wr = 0; end
                  c8ic_pkg::ALU_ADD: begin
                     fl = {7'd0, ({1'b0, vx} + {1'b0, vy} > 9'hFF)};
                     res = vx + vy;
                  end
                  c8ic_pkg::ALU_SUB: begin fl = {7'd0, (vx >= vy)}; res = vx - vy; end
                  c8ic_pkg::ALU_SHR: begin
                     if (shift_vy) vx = vy;
                     fl = {7'd0, vx[0]}; res = vx >> 1;
                  end
                  c8ic_pkg::ALU_SUBN: begin fl = {7'd0, (vy >= vx)}; res = vy - vx; end
                  c8ic_pkg::ALU_SHL: begin
                     if (shift_vy) vx = vy;
                     fl = {7'd0, vx[7]}; res = vx << 1;
                  end
                  default: wr = 0;
               endcase
               if (wr) begin
                  v[15] = fl;
                  v[x] = res;
               end
            end
            c8ic_pkg::GRP_SKIP_NE_REG: if (v[x] != v[y]) p += 13'd2;
            c8ic_pkg::GRP_LOAD_INDEX:  idx = {4'd0, nnn};
            c8ic_pkg::GRP_JUMP_OFFSET: begin
               p = {1'b0, nnn} + {5'd0, v[jump_vx ? x : 4'd0]} - 13'd2;
            end
            c8ic_pkg::GRP_RANDOM:      v[x] = r.rnd & nn;
            c8ic_pkg::GRP_DRAW:        e.display_changed = draw(x, y, n);
            c8ic_pkg::GRP_KEY: begin
               if (nn == c8ic_pkg::KEY_HELD && r.keys[x]) p += 13'd2;
               if (nn == c8ic_pkg::KEY_UP && !r.keys[x]) p += 13'd2;
            end
            default: begin
               case (nn)
                  c8ic_pkg::F_GET_DELAY: v[x] = dt;
                  c8ic_pkg::F_SET_DELAY: dt = v[x];
                  c8ic_pkg::F_SET_SOUND: st = v[x];
                  c8ic_pkg::F_ADD_INDEX: idx = idx + {8'd0, v[x]};
                  c8ic_pkg::F_WAIT_KEY: begin
                     if (r.pressed < c8ic_pkg::KEY_NONE) v[x] = {3'd0, r.pressed};
                     else begin
                        p -= 13'd2;
                        e.waiting_key = 1;
                     end
                  end
                  default: ;
               endcase
            end
         endcase
         pc = p + 13'd2;
      endfunction

      function void note(core_request r);
         core_result e;
         e = '{default: 0};
         case (r.op)
            c8ic_pkg::OPC_MEM_WRITE:  mem[r.addr] = r.data;
            c8ic_pkg::OPC_MEM_READ:   e.read_data = mem[r.addr];
            c8ic_pkg::OPC_EXECUTE:    execute(r, e);
            c8ic_pkg::OPC_TICK: begin
               if (dt != 0) dt--;
               if (st != 0) st--;
            end
            c8ic_pkg::OPC_PIXEL_READ: begin
               e.read_data = {7'd0, scr[r.py*c8ic_pkg::SCREEN_WIDTH + r.px]};
            end
            c8ic_pkg::OPC_REG_READ:   e.read_data = v[r.ridx];
            default: ;
         endcase
         e.pc = pc; e.index_value = idx; e.delay_value = dt; e.sound_value = st;
         expected_q.push_back(e);
      endfunction

      function void check(core_result a);
         core_result e;
         if (expected_q.size() == 0) begin
            $error("result with no item outstanding");
            failed = 1;
            return;
         end
         e = expected_q.pop_front();
         if (a.pc !== e.pc) begin
            $error("pc: expected %0h actual %0h", e.pc, a.pc); failed = 1;
         end
         if (a.index_value !== e.index_value) begin
            $error("index_value: expected %0h actual %0h", e.index_value, a.index_value);
            failed = 1;
         end
         if (a.delay_value !== e.delay_value) begin
            $error("delay_value: expected %0h actual %0h", e.delay_value, a.delay_value);
            failed = 1;
         end
         if (a.sound_value !== e.sound_value) begin
            $error("sound_value: expected %0h actual %0h", e.sound_value, a.sound_value);
            failed = 1;
         end
         if (a.read_data !== e.read_data) begin
            $error("read_data: expected %0h actual %0h", e.read_data, a.read_data);
            failed = 1;
         end
         if (a.stack_error !== e.stack_error) begin
            $error("stack_error: expected %0b actual %0b", e.stack_error, a.stack_error);
            failed = 1;
         end
         if (a.waiting_key !== e.waiting_key) begin
            $error("waiting_key: expected %0b actual %0b", e.waiting_key, a.waiting_key);
            failed = 1;
         end
         if (a.display_changed !== e.display_changed) begin
            $error("display_changed: expected %0b actual %0b", e.display_changed,
                   a.display_changed);
            failed = 1;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [55:0] rsp_tdata;
   logic        csr_we;
   logic [0:0]  csr_index, csr_wdata;

   core_scoreboard sb;
   int unsigned    gap_calls;
   int             results_seen;
   int             idle_cycles;

   chip8_instruction_core_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic int gap_len();
      int r;
      gap_calls++;
      if ((gap_calls / 64) % 5 == 4) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic core_request rand_request(logic [2:0] op);
      core_request r;
      r.op = op;
      r.addr = 12'($urandom); r.data = 8'($urandom); r.keys = 16'($urandom);
      r.pressed = 5'($urandom); r.rnd = 8'($urandom); r.px = 6'($urandom);
      r.py = 5'($urandom); r.ridx = 4'($urandom);
      return r;
   endfunction

   function automatic logic [15:0] rand_instruction();
      logic [15:0] i;
      i = 16'($urandom);
      case (c8ic_pkg::grp_type'(i[15:12]))
         c8ic_pkg::GRP_SYS: case ($urandom_range(0, 2))
            0: i = c8ic_pkg::INST_CLS;
            1: i = c8ic_pkg::INST_RET;
            default: ;
         endcase
         c8ic_pkg::GRP_KEY: case ($urandom_range(0, 2))
            0: i[7:0] = c8ic_pkg::KEY_HELD;
            1: i[7:0] = c8ic_pkg::KEY_UP;
            default: ;
         endcase
         c8ic_pkg::GRP_MISC: case ($urandom_range(0, 5))
            0: i[7:0] = c8ic_pkg::F_GET_DELAY;
            1: i[7:0] = c8ic_pkg::F_WAIT_KEY;
            2: i[7:0] = c8ic_pkg::F_SET_DELAY;
            3: i[7:0] = c8ic_pkg::F_SET_SOUND;
            4: i[7:0] = c8ic_pkg::F_ADD_INDEX;
            default: ;
         endcase
         default: ;
      endcase
      return i;
   endfunction

   task automatic send(core_request r);
      int g;
      req_tdata <= {r.ridx, r.py, r.px, r.rnd, r.pressed, r.keys, r.data, r.addr};
      req_tuser <= r.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note(r);
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_op(logic [2:0] op);
      send(rand_request(op));
   endtask

   task automatic send_write(logic [11:0] a, logic [7:0] d);
      core_request r;
      r = rand_request(c8ic_pkg::OPC_MEM_WRITE);
      r.addr = a; r.data = d;
      send(r);
   endtask

   // place an instruction at the fetch address, then run it
   task automatic send_program_step(logic [15:0] inst);
      logic [11:0] a;
      a = (sb.pc >= c8ic_pkg::PC_LIMIT) ? c8ic_pkg::PC_RESET[11:0] : sb.pc[11:0];
      send_write(a, inst[15:8]);
      send_write(a + 12'd1, inst[7:0]);
      send_op(c8ic_pkg::OPC_EXECUTE);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [0:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == c8ic_pkg::CSR_SHIFT_USES_VY) sb.shift_vy = val;
      else sb.jump_vx = val;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic directed_items();
      core_request r;
      send_write(12'h000, 8'hFF);
      send_write(12'hFFF, 8'h00);
      r = rand_request(c8ic_pkg::OPC_MEM_READ); r.addr = 12'h000; send(r);
      r = rand_request(c8ic_pkg::OPC_MEM_READ); r.addr = 12'hFFF; send(r);
      send_op(c8ic_pkg::OPC_TICK);
      r = rand_request(c8ic_pkg::OPC_PIXEL_READ); r.px = 6'd63; r.py = 5'd31; send(r);
      r = rand_request(c8ic_pkg::OPC_REG_READ); r.ridx = 4'hF; send(r);
      send_op(OPC_UNDEF_6);
      send_op(OPC_UNDEF_7);
      send_program_step(c8ic_pkg::INST_RET);       // return on empty stack
      send_program_step(16'h2000 | {4'd0, sb.pc[11:0]});   // call to itself
      repeat (c8ic_pkg::STACK_DEPTH) send_op(c8ic_pkg::OPC_EXECUTE);  // last one overflows
      send_program_step(16'h6F05);
      send_program_step(16'hF015);
      send_program_step(16'hD00F);
      send_program_step(c8ic_pkg::INST_CLS);
      send_program_step(16'h1FFF);       // runs into the end of memory
      send_op(c8ic_pkg::OPC_EXECUTE);
      send_op(c8ic_pkg::OPC_EXECUTE);
   endtask

   task automatic random_items(int count);
      int k;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(0, 19))
            0, 1:  send_write(12'($urandom), 8'($urandom));
            2:     send_op(c8ic_pkg::OPC_MEM_READ);
            3, 4:  send_op(c8ic_pkg::OPC_TICK);
            5, 6:  send_op(c8ic_pkg::OPC_PIXEL_READ);
            7:     send_op(c8ic_pkg::OPC_REG_READ);
            8:     send(rand_request(3'($urandom)));
            9:     send_op(c8ic_pkg::OPC_EXECUTE);
            default: send_program_step(rand_instruction());
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check('{pc: rsp_tdata[12:0], index_value: rsp_tdata[28:13],
                    delay_value: rsp_tdata[36:29], sound_value: rsp_tdata[44:37],
                    read_data: rsp_tdata[52:45], stack_error: rsp_tdata[53],
                    waiting_key: rsp_tdata[54], display_changed: rsp_tdata[55]});
         results_seen++;
      end
   end

   initial begin
      int g;
      bit held_off;
      held_off = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && results_seen >= 300) begin
            held_off = 1;
            g = LONG_HOLD;
         end else begin
            g = gap_len();
         end
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      sb = new();
      results_seen = 0;
      gap_calls = 0;
      idle_cycles = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0; req_tdata <= '0; req_tuser <= '0;
      csr_we <= 1'b0; csr_index <= '0; csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_csr(c8ic_pkg::CSR_SHIFT_USES_VY, 1'b0);
      write_csr(c8ic_pkg::CSR_JUMP_OFFSET_USES_VX, 1'b0);
      directed_items();
      random_items(90);
      wait_idle();
      write_csr(c8ic_pkg::CSR_SHIFT_USES_VY, 1'b1);
      write_csr(c8ic_pkg::CSR_JUMP_OFFSET_USES_VX, 1'b1);
      random_items(95);
      wait_idle();
      write_csr(c8ic_pkg::CSR_JUMP_OFFSET_USES_VX, 1'b0);
      random_items(95);
      wait_idle();
      write_csr(c8ic_pkg::CSR_SHIFT_USES_VY, 1'b0);
      write_csr(c8ic_pkg::CSR_JUMP_OFFSET_USES_VX, 1'b1);
      random_items(95);
      wait_idle();
      if (!sb.failed && sb.expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
